[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the number parser.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PRNP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PRNP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/prnp_pkg.sv]
// Shared types, constants and the digit decoder of the number parser.
// No dependencies; used by every module of the block.
`default_nettype none

package prnp_pkg;

	// Item kinds on the input channel
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Prefix letters at position one
	localparam logic [7:0] CHAR_X = 8'h78;
	localparam logic [7:0] CHAR_B = 8'h62;

	localparam int COUNT_W = 6;
	localparam int DEC_W   = 35;
	localparam int HEX_W   = 32;
	localparam int BIN_W   = 37;
	localparam int WORD_W  = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
	// Character count limits, prefix included for hex and binary
	localparam logic [COUNT_W-1:0] DEC_MAX_COUNT = 6'd10;
	localparam logic [COUNT_W-1:0] HEX_MAX_COUNT = 6'd10;
	localparam logic [COUNT_W-1:0] BIN_MAX_COUNT = 6'd34;
	localparam logic [COUNT_W-1:0] PREFIX_COUNT  = 6'd2;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [7:0]         second;
		logic [DEC_W-1:0]   dec;
		logic [HEX_W-1:0]   hex;
		logic [BIN_W-1:0]   bin;
		logic               bad_any;
		logic               bad_post;
	} prnp_state_t;

	// Hex digit value in bits 3:0, bit 4 set for a non-digit
	function automatic logic [4:0] digit_of(input logic [7:0] ch);
		logic [4:0] d;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			d = {1'b0, ch[3:0]};
		end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
			d = {1'b0, 4'(ch[3:0] + 4'd9)};
		end else begin
			d = 5'h10;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

[hdl/prefixed_radix_number_parser.sv]
// Top level of the prefixed radix number parser: input register and handshake.
// Depends on prnp_pkg, prnp_accum, prnp_final and assert_macros.svh.
//
//   channel | signals                       | transaction
//   --------+-------------------------------+-------------------------------
//   in      | in_valid, in_stall            | kind, character (one item)
//   out     | out_valid, out_stall          | success, value (one result)
//
// One item is taken per cycle while in_stall is low, set by the single input register stage.
// A character updates the accumulators in the cycle after its transaction; it never stalls.
// An end item passes the input register, then loads the output register that drives out_valid.
// in_stall rises only while an end item waits on a full, stalled output register.
// Reset clears the literal state and both valid flags, dropping any item or result they held.
`default_nettype none
`include "assert_macros.svh"

module prefixed_radix_number_parser (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         kind,
	input  wire logic [7:0]                   character,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              success,
	output logic [prnp_pkg::WORD_W-1:0]       value
);
	import prnp_pkg::*;

	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  char_s1;
	logic        adv_s1;
	logic        step;
	logic        done;
	prnp_state_t state;

	// Move the staged item on unless an end item meets a stalled full output
	assign adv_s1   = valid_s1 && (kind_s1 == KIND_CHAR || !out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign step     = adv_s1 && kind_s1 == KIND_CHAR;
	assign done     = adv_s1 && kind_s1 == KIND_END;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			char_s1 <= character;
		end
	end

	prnp_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.clear     (done),
		.character (char_s1),
		.state     (state)
	);

	prnp_final u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (done),
		.out_stall (out_stall),
		.state     (state),
		.out_valid (out_valid),
		.success   (success),
		.value     (value)
	);

	`PRNP_ASSERT_NXT(a_end_gives_result, done, out_valid, "end item did not produce a result")
	`PRNP_ASSERT_NXT(a_end_clears_state, done, state.count == '0, "state not cleared after end")
	`PRNP_ASSERT_IMP(a_fail_is_zero, out_valid && !success, value == '0, "failed result nonzero")
	`PRNP_ASSERT_IMP(a_char_never_stalls, valid_s1 && kind_s1 == KIND_CHAR, !in_stall,
		"character item stalled the input")

endmodule

`default_nettype wire

[hdl/prnp_accum.sv]
// Literal state of the number parser: count, prefix letter and the three
// radix accumulators. Depends on prnp_pkg.
`default_nettype none

module prnp_accum (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              clear,
	input  wire logic [7:0]        character,
	output prnp_pkg::prnp_state_t  state
);
	import prnp_pkg::*;

	prnp_state_t state_q;
	logic [4:0]  digit;
	logic        bad;
	logic [3:0]  v;
	logic        post;

	// Decode the character; a non-digit adds zero
	always_comb begin
		digit = digit_of(character);
		bad   = digit[4];
		v     = bad ? 4'd0 : digit[3:0];
		post  = (state_q.count >= PREFIX_COUNT);
	end

	// Advance on a character, drop everything on an end item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (clear) begin
			state_q <= '0;
		end else if (step) begin
			if (bad)
				state_q.bad_any <= 1'b1;
			state_q.dec <= (state_q.dec << 3) + (state_q.dec << 1) + DEC_W'(v);
			if (state_q.count == 6'd1)
				state_q.second <= character;
			if (post) begin
				if (bad)
					state_q.bad_post <= 1'b1;
				state_q.hex <= {state_q.hex[HEX_W-5:0], v};
				state_q.bin <= (state_q.bin << 1) + BIN_W'(v);
			end
			if (state_q.count != COUNT_MAX)
				state_q.count <= state_q.count + 6'd1;
		end
	end

	assign state = state_q;

endmodule

`default_nettype wire

[hdl/prnp_final.sv]
// Result stage of the number parser: radix choice, range checks and the
// output register. Depends on prnp_pkg.
`default_nettype none

module prnp_final (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         load,
	input  wire logic                         out_stall,
	input  wire prnp_pkg::prnp_state_t        state,
	output logic                              out_valid,
	output logic                              success,
	output logic [prnp_pkg::WORD_W-1:0]       value
);
	import prnp_pkg::*;

	logic              valid_q;
	logic              success_q;
	logic [WORD_W-1:0] value_q;
	logic              ok;
	logic [WORD_W-1:0] word;
	logic              long_enough;

	// Pick the radix and check length, characters and range
	always_comb begin
		long_enough = (state.count > PREFIX_COUNT);
		if (long_enough && state.second == CHAR_X) begin
			ok   = (state.count <= HEX_MAX_COUNT) && !state.bad_post;
			word = state.hex;
		end else if (long_enough && state.second == CHAR_B) begin
			ok   = (state.count <= BIN_MAX_COUNT) && !state.bad_post
			       && (state.bin[BIN_W-1:WORD_W] == '0);
			word = state.bin[WORD_W-1:0];
		end else begin
			ok   = (state.count <= DEC_MAX_COUNT) && !state.bad_any
			       && (state.dec[DEC_W-1:WORD_W] == '0);
			word = state.dec[WORD_W-1:0];
		end
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			success_q <= ok;
			value_q   <= ok ? word : '0;
		end
	end

	assign out_valid = valid_q;
	assign success   = success_q;
	assign value     = value_q;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for prefixed_radix_number_parser.
// Drives literal characters and end items, predicts each parse result and
// checks it on the output channel. Depends on prnp_pkg and the parser RTL.
module testbench;
	import prnp_pkg::*;

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
	} parser_item_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] word;
	} parse_result_t;

	typedef logic [7:0] text_t[$];

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = 1'b0;
	logic [7:0]  character = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        success;
	logic [31:0] value;

	parser_item_t  pending_items[$];
	parse_result_t results_due[$];
	logic          in_taken = 1'b0;
	int            items_taken = 0;
	int            items_queued = 0;
	int            errors = 0;
	int            send_idle_pct = 0;
	int            stall_pct = 0;
	int            hold_left = 0;
	logic          hold_done = 1'b0;

	// Literal state of the predictor
	logic [5:0]  seen_count = '0;
	logic [7:0]  prefix_char = '0;
	logic [34:0] dec_sum = '0;
	logic [31:0] hex_sum = '0;
	logic [36:0] bin_sum = '0;
	logic        bad_any = 1'b0;
	logic        bad_post = 1'b0;

	prefixed_radix_number_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.character (character),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.success   (success),
		.value     (value)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hex value of a character in bits 3:0, bit 4 set when it is no hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] ch);
		if (ch >= "0" && ch <= "9") return 5'(ch - "0");
		if (ch >= "a" && ch <= "f") return 5'(ch - "a" + 8'd10);
		if (ch >= "A" && ch <= "F") return 5'(ch - "A" + 8'd10);
		return 5'h10;
	endfunction

	// Advance the literal state by one item; an end item yields a result
	task automatic parse_item(input logic item_kind, input logic [7:0] ch);
		logic [4:0]    digit;
		logic          bad;
		logic          ok;
		logic [31:0]   word;
		parse_result_t res;
		if (item_kind == KIND_CHAR) begin
			digit = hex_value(ch);
			bad = digit[4];
			if (bad) begin
				bad_any = 1'b1;
				digit = '0;
			end
			dec_sum = dec_sum * 35'd10 + 35'(digit);
			if (seen_count == 6'd1) prefix_char = ch;
			if (seen_count >= 6'd2) begin
				if (bad) bad_post = 1'b1;
				hex_sum = {hex_sum[27:0], digit[3:0]};
				bin_sum = {bin_sum[35:0], 1'b0} + 37'(digit);
			end
			if (seen_count != COUNT_MAX) seen_count = seen_count + 6'd1;
		end else begin
			if (seen_count > 6'd2 && prefix_char == CHAR_X) begin
				ok = (seen_count <= 6'd10) && !bad_post;
				word = hex_sum;
			end else if (seen_count > 6'd2 && prefix_char == CHAR_B) begin
				ok = (seen_count <= 6'd34) && !bad_post && (bin_sum[36:32] == '0);
				word = bin_sum[31:0];
			end else begin
				ok = (seen_count <= 6'd10) && !bad_any && (dec_sum[34:32] == '0);
				word = dec_sum[31:0];
			end
			res.ok = ok;
			res.word = ok ? word : '0;
			results_due.push_back(res);
			seen_count = '0;
			prefix_char = '0;
			dec_sum = '0;
			hex_sum = '0;
			bin_sum = '0;
			bad_any = 1'b0;
			bad_post = 1'b0;
		end
	endtask

	function automatic text_t text_of(string s);
		text_t t;
		for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
		return t;
	endfunction

	function automatic string repeat_text(string s, int n);
		string r;
		r = "";
		for (int i = 0; i < n; i++) r = {r, s};
		return r;
	endfunction

	// Queue the characters of one literal followed by its end item
	task automatic queue_literal(text_t text);
		parser_item_t it;
		foreach (text[i]) begin
			it.kind = KIND_CHAR;
			it.ch = text[i];
			pending_items.push_back(it);
		end
		it.kind = KIND_END;
		it.ch = 8'($urandom);
		pending_items.push_back(it);
		items_queued += text.size() + 1;
	endtask

	// Build one mostly well-formed literal, with some noise and corruption
	task automatic queue_random_literal();
		text_t t;
		int    pick;
		int    len;
		string hex_chars;
		hex_chars = "0123456789abcdefABCDEF";
		pick = $urandom_range(99);
		if (pick < 30) begin
			if ($urandom_range(3) == 0) begin
				t = text_of("42949672");
				len = 2;
			end else begin
				len = $urandom_range(11);
			end
			for (int i = 0; i < len; i++) t.push_back(8'("0" + $urandom_range(9)));
		end else if (pick < 55) begin
			t.push_back(($urandom_range(4) == 0) ? 8'($urandom) : 8'("0"));
			t.push_back(CHAR_X);
			len = ($urandom_range(9) == 0) ? 9 : $urandom_range(8);
			for (int i = 0; i < len; i++) t.push_back(hex_chars[$urandom_range(21)]);
		end else if (pick < 80) begin
			t.push_back(($urandom_range(4) == 0) ? 8'($urandom) : 8'("0"));
			t.push_back(CHAR_B);
			len = ($urandom_range(4) == 0) ? $urandom_range(32, 34) : $urandom_range(1, 31);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(9) == 0) t.push_back(hex_chars[$urandom_range(21)]);
				else t.push_back(8'("0" + $urandom_range(1)));
			end
		end else if (pick < 90) begin
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++) t.push_back(hex_chars[$urandom_range(21)]);
		end else begin
			len = ($urandom_range(9) == 0) ? $urandom_range(64, 70) : $urandom_range(12);
			for (int i = 0; i < len; i++) t.push_back(8'($urandom));
		end
		if (t.size() > 0 && $urandom_range(9) == 0)
			t[$urandom_range(t.size() - 1)] = 8'($urandom);
		queue_literal(t);
	endtask

	// Offer the next item once the previous transaction has completed
	always @(negedge clk) begin : drive_items
		parser_item_t next_item;
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = pending_items.pop_front();
				in_valid <= 1'b1;
				kind <= next_item.kind;
				character <= next_item.ch;
			end else begin
				in_valid <= 1'b0;
				kind <= 1'($urandom);
				character <= 8'($urandom);
			end
		end
	end

	// Stall the output at random; once, hold it off long enough to back up the input
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && items_taken >= 900) begin
			hold_done <= 1'b1;
			hold_left <= 300;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Predict on each input transaction and check each output transaction
	always @(posedge clk) begin
		parse_result_t exp_res;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				parse_item(kind, character);
				items_taken++;
			end
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("unexpected result: success %0b value %h", success, value);
					errors++;
				end else begin
					exp_res = results_due.pop_front();
					if (success !== exp_res.ok) begin
						$error("success: expected %0b, got %0b", exp_res.ok, success);
						errors++;
					end
					if (value !== exp_res.word) begin
						$error("value: expected %h, got %h", exp_res.word, value);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int phase_send[4];
		int phase_stall[4];
		text_t t;
		phase_send = '{0, 50, 0, 25};
		phase_stall = '{0, 0, 50, 25};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed literals: limits, prefixes, bad characters, empty and long text
		queue_literal(text_of(""));
		queue_literal(text_of("0"));
		queue_literal(text_of("4294967295"));
		queue_literal(text_of("4294967296"));
		queue_literal(text_of("12345678901"));
		queue_literal(text_of("0000000042"));
		queue_literal(text_of("AB"));
		queue_literal(text_of("12g"));
		queue_literal(text_of("0xFFFFFFFF"));
		queue_literal(text_of("0x00000000"));
		queue_literal(text_of("0xaBcDeF01"));
		queue_literal(text_of("0x123456789"));
		queue_literal(text_of("zxC0DE"));
		queue_literal(text_of("0xg1"));
		queue_literal(text_of("0x"));
		queue_literal(text_of("0b"));
		queue_literal(text_of("0b2"));
		queue_literal(text_of("0b 1"));
		queue_literal(text_of({"0b", repeat_text("1", 32)}));
		queue_literal(text_of({"0b1", repeat_text("0", 32)}));
		queue_literal(text_of({"0b", repeat_text("F", 32)}));
		queue_literal(text_of(repeat_text("1", 70)));
		t = '{8'h00};
		queue_literal(t);
		t = '{8'hFF};
		queue_literal(t);

		// Random literals under each idling pattern
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_send[p];
			stall_pct = phase_stall[p];
			items_queued = 0;
			while (items_queued < 500) queue_random_literal();
			while (pending_items.size() > 0) @(posedge clk);
		end
		send_idle_pct = 0;
		stall_pct = 0;

		// Drain: last item taken, every result checked, then a short settle
		while (in_valid) @(posedge clk);
		while (results_due.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/prnp_pkg.sv
hdl/prnp_accum.sv
hdl/prnp_final.sv
hdl/prefixed_radix_number_parser.sv
tb/testbench.sv
